// File: src/achlp_pkg.sv
// Package for the ASCII-hex CAN line parser: item types, codes and constants.
package achlp_pkg;

    localparam int DEF_MAX_DATA_BYTES = 8;

    localparam logic [7:0] LINE_END      = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] HEX_TEN       = 8'd10;
    localparam logic [5:0] MIN_LINE_LEN  = 6'd7;
    localparam logic [5:0] HEADER_CHARS  = 6'd5;
    localparam logic [5:0] POS_MAX       = 6'd63;
    localparam logic [31:0] FRAME_OVERHEAD = 32'd6;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] KIND_GOOD    = 2'd0;
    localparam logic [1:0] KIND_BAD_LEN = 2'd1;
    localparam logic [1:0] KIND_COUNT   = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_in;
    } char_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  bus_id;
        logic [15:0] frame_id;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic [31:0] byte_count;
    } res_item_t;

endpackage

// File: src/ascii_hex_can_line_parser.sv
// Top level of the ASCII-hex CAN line parser.
//
//  channel | direction | handshake              | payload
//  char    | in        | char_valid/char_ready  | char_item (cmd, char_in)
//  res     | out       | res_valid/res_ready    | res_item (kind, ids, payload, count)
//
// One item is taken per cycle while char_ready is high; a line end or a read command
// yields a result in the output register, or in a second output stage that holds one
// more result while res_ready is low, so char_ready drops only when both are full.
// Reset (rst_n low, asynchronous) clears the line position, the held frame
// data and the byte counter. While the second stage is full every item waits,
// whether or not it causes a result.
module ascii_hex_can_line_parser
    import achlp_pkg::*;
#(
    parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_item_t char_item,
    output logic       res_valid,
    input  logic       res_ready,
    output res_item_t  res_item
);

    localparam logic [5:0] MaxLineLen = 6'(5 + 2 * MAX_DATA_BYTES);
    localparam logic [4:0] MaxBytes   = 5'(MAX_DATA_BYTES);

    logic [5:0]  line_position_reg, line_position_next;
    logic [7:0]  held_bus_id_reg, held_bus_id_next;
    logic [15:0] held_frame_id_reg, held_frame_id_next;
    logic [63:0] held_payload_reg, held_payload_next;
    logic [63:0] line_payload_reg, line_payload_next;
    logic [3:0]  pending_nibble_reg, pending_nibble_next;
    logic [31:0] received_bytes_reg, received_bytes_next;

    logic        res_valid_reg;
    res_item_t   res_item_reg;
    logic        skid_valid_reg;
    res_item_t   skid_item_reg;

    logic        accept;
    logic        take;
    logic        have_res;
    res_item_t   new_res;
    logic [3:0]  digit;
    logic [5:0]  p;
    logic [3:0]  dlc;
    logic [63:0] keep_mask;
    logic [4:0]  byte_idx;
    logic [5:0]  data_off;
    logic [5:0]  dlc_full;
    logic        len_bad;

    assign char_ready = !skid_valid_reg;
    assign accept     = char_valid && char_ready;
    assign take       = res_valid_reg && res_ready;
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;
    assign p          = line_position_reg;

    // digit value taken mod 16 for any character
    always_comb
    begin
        if (char_item.char_in >= CHAR_UPPER_A)
            digit = 4'(char_item.char_in - CHAR_UPPER_A + HEX_TEN);
        else
            digit = 4'(char_item.char_in - CHAR_ZERO);
    end

    always_comb
    begin
        data_off = p - HEADER_CHARS - 6'd1;
        byte_idx = data_off[5:1];
        dlc_full = (p - HEADER_CHARS) >> 1;
        dlc      = dlc_full[3:0];
        len_bad  = (p < MIN_LINE_LEN) || (p > MaxLineLen) || !p[0];
        for (int i = 0; i < 8; i++)
            keep_mask[8*i +: 8] = (4'(i) < dlc) ? 8'hFF : 8'h00;
    end

    always_comb
    begin
        line_position_next  = line_position_reg;
        held_bus_id_next    = held_bus_id_reg;
        held_frame_id_next  = held_frame_id_reg;
        held_payload_next   = held_payload_reg;
        line_payload_next   = line_payload_reg;
        pending_nibble_next = pending_nibble_reg;
        received_bytes_next = received_bytes_reg;
        have_res            = 1'b0;
        new_res             = '0;

        if (accept)
        begin
            if (char_item.cmd == CMD_READ)
            begin
                have_res               = 1'b1;
                new_res.result_kind    = KIND_COUNT;
                new_res.byte_count     = received_bytes_reg;
                received_bytes_next    = '0;
            end
            else if (char_item.char_in == LINE_END)
            begin
                have_res           = 1'b1;
                line_position_next = '0;
                if (len_bad)
                begin
                    new_res.result_kind = KIND_BAD_LEN;
                end
                else
                begin
                    held_payload_next   = (held_payload_reg & ~keep_mask)
                                        | (line_payload_reg & keep_mask);
                    received_bytes_next = received_bytes_reg + 32'(dlc) + FRAME_OVERHEAD;
                    new_res.result_kind = KIND_GOOD;
                    new_res.bus_id      = held_bus_id_reg;
                    new_res.frame_id    = held_frame_id_reg;
                    new_res.length_code = dlc;
                    new_res.payload     = held_payload_next;
                end
            end
            else
            begin
                if (p == 6'd0)
                    held_bus_id_next = char_item.char_in;
                else if (p < HEADER_CHARS)
                    held_frame_id_next[4*(3'd4 - p[2:0]) +: 4] = digit;
                else if (p[0])
                    pending_nibble_next = digit;
                else if (byte_idx < MaxBytes)
                    line_payload_next[8*byte_idx[2:0] +: 8] = {pending_nibble_reg, digit};

                if (p < POS_MAX)
                    line_position_next = p + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_position_reg  <= '0;
            held_bus_id_reg    <= '0;
            held_frame_id_reg  <= '0;
            held_payload_reg   <= '0;
            line_payload_reg   <= '0;
            pending_nibble_reg <= '0;
            received_bytes_reg <= '0;
            res_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            line_position_reg  <= line_position_next;
            held_bus_id_reg    <= held_bus_id_next;
            held_frame_id_reg  <= held_frame_id_next;
            held_payload_reg   <= held_payload_next;
            line_payload_reg   <= line_payload_next;
            pending_nibble_reg <= pending_nibble_next;
            received_bytes_reg <= received_bytes_next;

            if (skid_valid_reg)
            begin
                // advance the held item once the output stage drains
                if (take)
                begin
                    res_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (have_res)
            begin
                if (!res_valid_reg || take)
                    res_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                res_item_reg <= skid_item_reg;
        end
        else if (have_res)
        begin
            if (!res_valid_reg || take)
                res_item_reg <= new_res;
            else
                skid_item_reg <= new_res;
        end
    end

endmodule

// File: verif/tb.sv
// Testbench for the ASCII-hex CAN line parser: directed table, random lines, result checking.
module tb
    import achlp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES     = DEF_MAX_DATA_BYTES;
    localparam int MAX_LINE      = HEADER_CHARS + 2 * MAX_BYTES;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RUN_LIMIT_NS  = 10_000_000;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_ready;
    char_item_t char_item;
    logic       res_valid;
    logic       res_ready;
    res_item_t  res_item;

    ascii_hex_can_line_parser i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    // one input item with an optional hand-written expectation
    typedef struct packed {
        char_item_t item;
        logic       fixed;
        res_item_t  fixed_res;
    } stim_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  ch;
        logic        fixed;
        logic [1:0]  kind;
        logic [31:0] count;
    } dir_row_t;

    localparam int DIR_ROWS = 27;
    dir_row_t dir_table [DIR_ROWS] = '{
        '{CMD_READ, 8'h00,    1'b1, KIND_COUNT,   32'd0},  // counter after reset
        '{CMD_CHAR, LINE_END, 1'b1, KIND_BAD_LEN, 32'd0},  // empty line
        '{CMD_CHAR, 8'hFF,    1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "F",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "F",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "F",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "F",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "F",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "F",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, LINE_END, 1'b0, KIND_GOOD,    32'd0},
        '{CMD_READ, 8'hFF,    1'b1, KIND_COUNT,   32'd7},  // one byte plus overhead
        '{CMD_CHAR, 8'h00,    1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "0",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "0",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "0",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "0",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, 8'h7F,    1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, LINE_END, 1'b1, KIND_BAD_LEN, 32'd0},  // even length
        '{CMD_READ, LINE_END, 1'b1, KIND_COUNT,   32'd0},  // char ignored on read
        '{CMD_CHAR, "2",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "a",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "9",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_READ, 8'h55,    1'b1, KIND_COUNT,   32'd0},  // read inside a line
        '{CMD_CHAR, "3",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "8",      1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, 8'h80,    1'b0, KIND_GOOD,    32'd0},
        '{CMD_CHAR, "g",      1'b0, KIND_GOOD,    32'd0}
    };

    stim_t     stim_q [$];
    res_item_t line_results_q [$];
    int        mismatch_count;
    int        accepted_count;

    // parser state as seen from outside
    logic [5:0]  line_pos;
    logic [7:0]  line_bus_id;
    logic [15:0] line_frame_id;
    logic [63:0] frame_payload;
    logic [63:0] line_payload;
    logic [3:0]  high_nibble;
    logic [31:0] byte_total;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CHAR_UPPER_A)
            v = c - CHAR_UPPER_A + HEX_TEN;
        else
            v = c - CHAR_ZERO;
        return v[3:0];
    endfunction

    function automatic bit parse_line_char(input char_item_t it, output res_item_t res);
        int          p;
        int          dlc;
        int          idx;
        logic [63:0] mask;
        logic [3:0]  nib;
        p   = line_pos;
        nib = hex_nibble(it.char_in);
        res = '0;
        if (it.cmd == CMD_READ)
        begin
            res.result_kind = KIND_COUNT;
            res.byte_count  = byte_total;
            byte_total      = '0;
            return 1'b1;
        end
        if (it.char_in == LINE_END)
        begin
            line_pos = '0;
            if (p < MIN_LINE_LEN || p > MAX_LINE || p % 2 == 0)
            begin
                res.result_kind = KIND_BAD_LEN;
                return 1'b1;
            end
            dlc = (p - HEADER_CHARS) / 2;
            if (dlc >= 8)
                mask = '1;
            else
                mask = (64'd1 << (8 * dlc)) - 64'd1;
            frame_payload   = (frame_payload & ~mask) | (line_payload & mask);
            byte_total      = byte_total + 32'(dlc) + FRAME_OVERHEAD;
            res.result_kind = KIND_GOOD;
            res.bus_id      = line_bus_id;
            res.frame_id    = line_frame_id;
            res.length_code = 4'(dlc);
            res.payload     = frame_payload;
            return 1'b1;
        end
        if (p == 0)
            line_bus_id = it.char_in;
        else if (p < HEADER_CHARS)
            line_frame_id[4 * (4 - p) +: 4] = nib;
        else if (p % 2 == 1)
            high_nibble = nib;
        else
        begin
            idx = (p - HEADER_CHARS - 1) / 2;
            if (idx < MAX_BYTES)
                line_payload[8 * idx +: 8] = {high_nibble, nib};
        end
        if (p < POS_MAX)
            line_pos = 6'(p + 1);
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic add_item(input logic cmd, input logic [7:0] ch, input logic fixed,
                            input res_item_t fixed_res);
        stim_t s;
        s.item.cmd     = cmd;
        s.item.char_in = ch;
        s.fixed        = fixed;
        s.fixed_res    = fixed_res;
        stim_q.push_back(s);
    endtask

    // occasionally slip a counter read in front of a line character
    task automatic add_char(input logic [7:0] ch);
        if ($urandom_range(0, 99) < 3)
            add_item(CMD_READ, 8'($urandom_range(0, 255)), 1'b0, '0);
        add_item(CMD_CHAR, ch, 1'b0, '0);
    endtask

    function automatic logic [7:0] any_but_end();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == LINE_END)
            c = ~c;
        return c;
    endfunction

    function automatic logic [7:0] digit_char();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        v   = $urandom_range(0, 15);
        if (sel == 0)
            return any_but_end();
        if (sel == 1)
            return 8'(CHAR_LOWER_A + $urandom_range(0, 5));
        if (v < 10)
            return 8'(CHAR_ZERO + v);
        return 8'(CHAR_UPPER_A + v - 10);
    endfunction

    task automatic build_stimulus();
        res_item_t fixed_res;
        int        len;
        int        sel;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            fixed_res             = '0;
            fixed_res.result_kind = dir_table[i].kind;
            fixed_res.byte_count  = dir_table[i].count;
            add_item(dir_table[i].cmd, dir_table[i].ch, dir_table[i].fixed, fixed_res);
        end
        add_item(CMD_CHAR, LINE_END, 1'b0, '0);
        while (stim_q.size() < DIR_ROWS + RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                len = HEADER_CHARS + 2 * $urandom_range(1, MAX_BYTES);
            else if (sel < 90)
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(22, 70)
                                                   : $urandom_range(0, 24);
            else
                len = $urandom_range(1, 12);
            if (sel >= 90)
            begin
                // noise: raw bytes, line ends included
                for (int k = 0; k < len; k++)
                    add_char(8'($urandom_range(0, 255)));
            end
            else
            begin
                for (int k = 0; k < len; k++)
                    add_char(k == 0 ? any_but_end() : digit_char());
                add_char(LINE_END);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    // receiver: stall pattern changes after each random span of cycles
    initial
    begin
        int mode;
        int span;
        int cyc;
        res_ready <= 1'b0;
        cyc = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 200);
            repeat (span)
            begin
                @(posedge clk);
                cyc++;
                case (mode)
                    0: res_ready <= 1'b1;
                    1: res_ready <= 1'($urandom_range(0, 1));
                    2: res_ready <= ($urandom_range(0, 7) == 0);
                    default: res_ready <= (cyc % 5 != 0);
                endcase
            end
        end
    end

    // scoreboard: predict on accepted input, compare on accepted result
    always @(posedge clk)
    begin
        res_item_t predicted;
        res_item_t want;
        if (rst_n)
        begin
            if (char_valid && char_ready)
            begin
                if (parse_line_char(stim_q[accepted_count].item, predicted))
                begin
                    if (stim_q[accepted_count].fixed)
                        line_results_q.push_back(stim_q[accepted_count].fixed_res);
                    else
                        line_results_q.push_back(predicted);
                end
                accepted_count++;
            end
            if (res_valid && res_ready)
            begin
                if (line_results_q.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = line_results_q.pop_front();
                    check_field("result_kind", 64'(res_item.result_kind),
                                64'(want.result_kind));
                    check_field("bus_id", 64'(res_item.bus_id), 64'(want.bus_id));
                    check_field("frame_id", 64'(res_item.frame_id), 64'(want.frame_id));
                    check_field("length_code", 64'(res_item.length_code),
                                64'(want.length_code));
                    check_field("payload", res_item.payload, want.payload);
                    check_field("byte_count", 64'(res_item.byte_count),
                                64'(want.byte_count));
                end
            end
        end
    end

    // sender: bursts of items with random gaps
    initial
    begin
        int idx;
        int burst;
        int gap;
        bit paused;
        rst_n          <= 1'b0;
        char_valid     <= 1'b0;
        char_item      <= '0;
        mismatch_count = 0;
        accepted_count = 0;
        line_pos       = '0;
        line_bus_id    = '0;
        line_frame_id  = '0;
        frame_payload  = '0;
        line_payload   = '0;
        high_nibble    = '0;
        byte_total     = '0;
        paused         = 1'b0;
        build_stimulus();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idx = 0;
        while (idx < stim_q.size())
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && idx < stim_q.size())
            begin
                char_valid <= 1'b1;
                char_item  <= stim_q[idx].item;
                do
                    @(posedge clk);
                while (!char_ready);
                idx++;
                burst--;
            end
            if (!paused && idx > stim_q.size() / 2)
            begin
                // hold until the parser has emptied out
                paused = 1'b1;
                char_valid <= 1'b0;
                @(posedge clk);
                while (line_results_q.size() != 0)
                    @(posedge clk);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        char_valid <= 1'b0;
        @(posedge clk);
        while (line_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
